// ===== design/aits_pkg.sv =====
// ----------------------------------------------------------------------------
// aits_pkg
// Shared widths, codes and item types of the two-point analog input scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package aits_pkg;

   localparam int SAMPLE_W   = 29;
   localparam int MV_W       = 15;
   localparam int RATIO_W    = 11;
   localparam int DZ_W       = 14;
   localparam int OUT_W      = 32;
   localparam int REGION_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;
   localparam int FRAC_W     = 24;

   // gain divider: |dratio|*2^24 by |dmv|
   localparam int GQ_W = RATIO_W + FRAC_W;
   localparam int GR_W = MV_W + 1;
   // offset divide by 1000: |y1 - high_mv*gain| < 2^46, taken as
   // ((x >> 3) * RCP_125) >> 50, one 11-bit digit of RCP_125 per cell
   localparam int OQ_W      = 46;
   localparam int ON_W      = OQ_W - 3;
   localparam int RC_W      = 11;
   localparam int OFS_CELLS = 4;
   localparam int OA_W      = ON_W + RC_W + 1;
   localparam int OFS_SHIFT = 50 - OFS_CELLS * RC_W;
   localparam logic [OFS_CELLS*RC_W-1:0] RCP_125 = 44'd9007199254741;
   localparam int DIFF_W = OQ_W + 2;

   localparam int MV_PER_V    = 1000;
   localparam int RATIO_STEP  = 16777;
   localparam int DEAD_STEP   = 1677;

   localparam int PROD_W = OUT_W + SAMPLE_W;
   localparam int MVP_W  = SAMPLE_W + 11;
   localparam int MVQ_W  = MVP_W - FRAC_W;
   localparam int DZL_W  = DZ_W + 11;

   localparam int LATENCY = GQ_W + OFS_CELLS + 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_MV     = 3'd0,
      CSR_LOW_RATIO  = 3'd1,
      CSR_HIGH_MV    = 3'd2,
      CSR_HIGH_RATIO = 3'd3,
      CSR_DEAD_ZONE  = 3'd4
   } csr_idx_type;

   typedef enum logic [REGION_W-1:0] {
      REGION_LINEAR = 2'd0,
      REGION_HIGH   = 2'd1,
      REGION_LOW    = 2'd2,
      REGION_DEAD   = 2'd3
   } region_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [MV_W-1:0]     low_mv;
      logic signed [RATIO_W-1:0]  low_ratio;
      logic signed [MV_W-1:0]     high_mv;
      logic signed [RATIO_W-1:0]  high_ratio;
      logic [DZ_W-1:0]            dead_zone;
      logic signed [OUT_W-1:0]    gain;
   } ctx_type;

   typedef struct packed {
      logic [GR_W-1:0] rem;
      logic [GQ_W-1:0] qn;
      logic [GR_W-1:0] dv;
      logic            neg;
   } gdiv_type;

   typedef struct packed {
      logic [OA_W-1:0] acc;
      logic [ON_W-1:0] n;
      logic            neg;
   } odiv_type;

endpackage

`default_nettype wire

// ===== design/analog_input_two_point_scaler.sv =====
// ----------------------------------------------------------------------------
// analog_input_two_point_scaler
// Pipeline: 35 gain cells, one product stage, four offset cells, three output
// stages. Throughput: one beat per cycle; busy is always low and the receiver
// cannot stall.
// Reset clears the pipeline valid bits and loads the default calibration.
// ----------------------------------------------------------------------------
`default_nettype none

module analog_input_two_point_scaler
   import aits_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]       csr_data,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic signed [SAMPLE_W-1:0]  req_sample_q24,
   output logic                             rsp_valid,
   output logic signed [OUT_W-1:0]          rsp_scaled_q24,
   output logic [REGION_W-1:0]              rsp_region
);

   logic signed [MV_W-1:0]    low_mv_ff;
   logic signed [RATIO_W-1:0] low_ratio_ff;
   logic signed [MV_W-1:0]    high_mv_ff;
   logic signed [RATIO_W-1:0] high_ratio_ff;
   logic [DZ_W-1:0]           dead_zone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_mv_ff     <= '0;
         low_ratio_ff  <= '0;
         high_mv_ff    <= MV_W'(10000);
         high_ratio_ff <= RATIO_W'(1000);
         dead_zone_ff  <= '0;
      end else if (csr_write) begin
         case (csr_idx_type'(csr_index))
            CSR_LOW_MV:     low_mv_ff     <= csr_data[MV_W-1:0];
            CSR_LOW_RATIO:  low_ratio_ff  <= csr_data[RATIO_W-1:0];
            CSR_HIGH_MV:    high_mv_ff    <= csr_data[MV_W-1:0];
            CSR_HIGH_RATIO: high_ratio_ff <= csr_data[RATIO_W-1:0];
            CSR_DEAD_ZONE:  dead_zone_ff  <= csr_data[DZ_W-1:0];
            default: ;
         endcase
      end
   end

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // gain chain
   logic     g_valid [0:GQ_W];
   ctx_type  g_ctx   [0:GQ_W];
   gdiv_type g_div   [0:GQ_W];

   logic signed [RATIO_W:0] d_ratio;
   logic signed [MV_W:0]    d_mv;
   logic [RATIO_W-1:0]      d_ratio_mag;
   logic [MV_W:0]           d_mv_mag;

   always_comb begin
      d_ratio     = (RATIO_W+1)'(high_ratio_ff) - (RATIO_W+1)'(low_ratio_ff);
      d_mv        = (MV_W+1)'(high_mv_ff) - (MV_W+1)'(low_mv_ff);
      d_ratio_mag = d_ratio[RATIO_W] ? RATIO_W'(-d_ratio) : d_ratio[RATIO_W-1:0];
      d_mv_mag    = d_mv[MV_W] ? -d_mv : d_mv;

      g_valid[0]            = accept;
      g_ctx[0].sample       = req_sample_q24;
      g_ctx[0].low_mv       = low_mv_ff;
      g_ctx[0].low_ratio    = low_ratio_ff;
      g_ctx[0].high_mv      = high_mv_ff;
      g_ctx[0].high_ratio   = high_ratio_ff;
      g_ctx[0].dead_zone    = dead_zone_ff;
      g_ctx[0].gain         = '0;
      g_div[0].rem          = '0;
      g_div[0].qn           = {d_ratio_mag, {FRAC_W{1'b0}}};
      g_div[0].dv           = d_mv_mag;
      g_div[0].neg          = d_ratio[RATIO_W] ^ d_mv[MV_W];
   end

   for (genvar i = 0; i < GQ_W; i++) begin : g_gain
      aits_gain_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (g_valid[i]),
         .ctx_i   (g_ctx[i]),
         .div_i   (g_div[i]),
         .valid_o (g_valid[i+1]),
         .ctx_o   (g_ctx[i+1]),
         .div_o   (g_div[i+1])
      );
   end

   // product stage: y1 - high_mv*gain
   logic                     b_valid_ff;
   ctx_type                  b_ctx_ff;
   logic signed [DIFF_W-1:0] b_diff_ff;
   logic [GQ_W-1:0]          gain_q;
   logic signed [OUT_W-1:0]  gain_w;
   logic signed [DIFF_W-1:0] hm_x;
   logic signed [DIFF_W-1:0] gain_x;
   logic signed [DIFF_W-1:0] y1_x;
   ctx_type                  b_ctx_in;

   always_comb begin
      gain_q   = g_div[GQ_W].neg ? -g_div[GQ_W].qn : g_div[GQ_W].qn;
      gain_w   = gain_q[OUT_W-1:0];
      hm_x     = DIFF_W'(g_ctx[GQ_W].high_mv);
      gain_x   = DIFF_W'(gain_w);
      y1_x     = DIFF_W'(g_ctx[GQ_W].high_ratio) <<< FRAC_W;
      b_ctx_in = g_ctx[GQ_W];
      b_ctx_in.gain = gain_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= g_valid[GQ_W];
      end
   end

   always_ff @(posedge clock) begin
      b_ctx_ff  <= b_ctx_in;
      b_diff_ff <= y1_x - hm_x * gain_x;
   end

   // offset chain
   logic     o_valid [0:OFS_CELLS];
   ctx_type  o_ctx   [0:OFS_CELLS];
   odiv_type o_div   [0:OFS_CELLS];
   logic [DIFF_W-1:0] diff_mag;

   always_comb begin
      diff_mag     = b_diff_ff[DIFF_W-1] ? DIFF_W'(-b_diff_ff) : DIFF_W'(b_diff_ff);
      o_valid[0]   = b_valid_ff;
      o_ctx[0]     = b_ctx_ff;
      o_div[0].acc = '0;
      o_div[0].n   = diff_mag[ON_W+2:3];
      o_div[0].neg = b_diff_ff[DIFF_W-1];
   end

   for (genvar j = 0; j < OFS_CELLS; j++) begin : g_ofs
      aits_ofs_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (o_valid[j]),
         .ctx_i   (o_ctx[j]),
         .div_i   (o_div[j]),
         .rcp_i   (RCP_125[j*RC_W +: RC_W]),
         .valid_o (o_valid[j+1]),
         .ctx_o   (o_ctx[j+1]),
         .div_o   (o_div[j+1])
      );
   end

   // linear product and millivolt stage
   logic                     e_valid_ff;
   ctx_type                  e_ctx_ff;
   logic signed [OUT_W-1:0]  e_offset_ff;
   logic signed [PROD_W-1:0] e_prod_ff;
   logic signed [MVQ_W-1:0]  e_mv_ff;
   logic [OUT_W-1:0]         ofs_m;
   logic [OUT_W-1:0]         ofs_q;
   logic signed [PROD_W-1:0] s_px;
   logic signed [PROD_W-1:0] g_px;
   logic signed [MVP_W-1:0]  s_mx;
   logic signed [MVP_W-1:0]  mvp;

   always_comb begin
      ofs_m = o_div[OFS_CELLS].acc[OFS_SHIFT +: OUT_W];
      ofs_q = o_div[OFS_CELLS].neg ? -ofs_m : ofs_m;
      s_px  = PROD_W'(o_ctx[OFS_CELLS].sample);
      g_px  = PROD_W'(o_ctx[OFS_CELLS].gain);
      s_mx  = MVP_W'(o_ctx[OFS_CELLS].sample);
      mvp   = s_mx * MVP_W'(MV_PER_V);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= o_valid[OFS_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      e_ctx_ff    <= o_ctx[OFS_CELLS];
      e_offset_ff <= ofs_q;
      e_prod_ff   <= s_px * g_px;
      e_mv_ff     <= mvp[MVP_W-1:FRAC_W];
   end

   // region select
   logic                    f_valid_ff;
   logic signed [OUT_W-1:0] f_res_ff;
   region_type              f_region_ff;
   logic [DZ_W-1:0]         f_dz_ff;
   logic signed [OUT_W-1:0] f_res_in;
   region_type              f_region_in;
   logic signed [MVQ_W-1:0] hm_w;
   logic signed [MVQ_W-1:0] lm_w;
   logic signed [OUT_W-1:0] lin;

   always_comb begin
      hm_w = MVQ_W'(e_ctx_ff.high_mv);
      lm_w = MVQ_W'(e_ctx_ff.low_mv);
      lin  = e_prod_ff[FRAC_W+OUT_W-1:FRAC_W] + e_offset_ff;
      if (e_mv_ff >= hm_w) begin
         f_res_in    = OUT_W'(e_ctx_ff.high_ratio) * OUT_W'(RATIO_STEP);
         f_region_in = REGION_HIGH;
      end else if (e_mv_ff <= lm_w) begin
         f_res_in    = OUT_W'(e_ctx_ff.low_ratio) * OUT_W'(RATIO_STEP);
         f_region_in = REGION_LOW;
      end else begin
         f_res_in    = lin;
         f_region_in = REGION_LINEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f_res_ff    <= f_res_in;
      f_region_ff <= f_region_in;
      f_dz_ff     <= e_ctx_ff.dead_zone;
   end

   // dead zone and output register
   logic                  rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_scaled_ff;
   region_type            rsp_region_ff;
   logic signed [OUT_W:0] res_x;
   logic [OUT_W:0]        res_mag;
   logic [DZL_W-1:0]      dz_lim;

   always_comb begin
      res_x   = (OUT_W+1)'(f_res_ff);
      res_mag = res_x[OUT_W] ? (OUT_W+1)'(-res_x) : (OUT_W+1)'(res_x);
      dz_lim  = DZL_W'(f_dz_ff) * DZL_W'(DEAD_STEP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (res_mag < (OUT_W+1)'(dz_lim)) begin
         rsp_scaled_ff <= '0;
         rsp_region_ff <= REGION_DEAD;
      end else begin
         rsp_scaled_ff <= f_res_ff;
         rsp_region_ff <= f_region_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scaled_q24 = rsp_scaled_ff;
   assign rsp_region     = rsp_region_ff;

   a_dead_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_region == REGION_DEAD |-> rsp_scaled_q24 == '0)
      else $error("dead zone beat with nonzero result");

   a_beat_in_out : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result beat without matching request");

   a_beat_out_in : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("request beat lost");

endmodule

`default_nettype wire

// ===== design/aits_gain_cell.sv =====
// ----------------------------------------------------------------------------
// aits_gain_cell
// One restoring step of the gain divider; carries the beat's context along.
// ----------------------------------------------------------------------------
`default_nettype none

module aits_gain_cell
   import aits_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     valid_i,
   input  wire ctx_type  ctx_i,
   input  wire gdiv_type div_i,
   output logic          valid_o,
   output ctx_type       ctx_o,
   output gdiv_type      div_o
);

   logic                valid_ff;
   ctx_type             ctx_ff;
   gdiv_type            div_ff;
   gdiv_type            div_in;
   logic [GR_W:0]       trial;
   logic [GR_W:0]       diff;

   always_comb begin
      trial  = {div_i.rem, div_i.qn[GQ_W-1]};
      diff   = trial - {1'b0, div_i.dv};
      div_in = div_i;
      if (trial >= {1'b0, div_i.dv}) begin
         div_in.rem = diff[GR_W-1:0];
         div_in.qn  = {div_i.qn[GQ_W-2:0], 1'b1};
      end else begin
         div_in.rem = trial[GR_W-1:0];
         div_in.qn  = {div_i.qn[GQ_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff <= ctx_i;
      div_ff <= div_in;
   end

   assign valid_o = valid_ff;
   assign ctx_o   = ctx_ff;
   assign div_o   = div_ff;

endmodule

`default_nettype wire

// ===== design/aits_ofs_cell.sv =====
// ----------------------------------------------------------------------------
// aits_ofs_cell
// One digit step of the reciprocal multiply that divides the offset by 1000.
// ----------------------------------------------------------------------------
`default_nettype none

module aits_ofs_cell
   import aits_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            valid_i,
   input  wire ctx_type         ctx_i,
   input  wire odiv_type        div_i,
   input  wire logic [RC_W-1:0] rcp_i,
   output logic                 valid_o,
   output ctx_type              ctx_o,
   output odiv_type             div_o
);

   logic                   valid_ff;
   ctx_type                ctx_ff;
   odiv_type               div_ff;
   odiv_type               div_in;
   logic [ON_W+RC_W-1:0]   prod;
   logic [OA_W-1:0]        sum;

   // low digit first; bits below the digit are final and drop off
   always_comb begin
      prod       = (ON_W+RC_W)'(div_i.n) * (ON_W+RC_W)'(rcp_i);
      sum        = div_i.acc + OA_W'(prod);
      div_in     = div_i;
      div_in.acc = OA_W'(sum[OA_W-1:RC_W]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff <= ctx_i;
      div_ff <= div_in;
   end

   assign valid_o = valid_ff;
   assign ctx_o   = ctx_ff;
   assign div_o   = div_ff;

endmodule

`default_nettype wire
